// ----- sv/wcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared types, constants and helpers of the watch / stopwatch block.
// ----------------------------------------------------------------------------
package wcs_pkg;

  localparam int TICK_COUNT_WIDTH = 16;
  localparam int HOLD_WIDTH       = TICK_COUNT_WIDTH + 1;
  localparam int TPS_WIDTH        = 16;
  localparam int CMP_WIDTH        = 32;

  // APB register map
  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;
  localparam logic REG_TICKS_PER_SECOND = 1'b0;

  localparam logic [TPS_WIDTH-1:0] TPS_RESET    = TPS_WIDTH'(1000);
  localparam logic [TPS_WIDTH-1:0] TPS5_RESET   = TPS_WIDTH'(1000 / 5);
  localparam logic [TPS_WIDTH-1:0] TPS100_RESET = TPS_WIDTH'(1000 / 100);

  // reciprocal multipliers, exact over the whole 16-bit range
  localparam int          RECIP_W      = 2 * TPS_WIDTH + 1;
  localparam logic [16:0] DIV5_MUL     = 17'd52429;
  localparam int          DIV5_SHIFT   = 18;
  localparam logic [16:0] DIV100_MUL   = 17'd83887;
  localparam int          DIV100_SHIFT = 23;

  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [6:0] CENTI_MAX  = 7'd99;

  typedef enum logic [2:0] {
    MODE_RUN       = 3'd0,
    MODE_SET_HOUR  = 3'd1,
    MODE_SET_MIN   = 3'd2,
    MODE_SET_SEC   = 3'd3,
    MODE_STOPWATCH = 3'd4
  } mode_e;

  typedef struct packed {
    logic [TPS_WIDTH-1:0] tps;
    logic [TPS_WIDTH-1:0] tps_div5;
    logic [TPS_WIDTH-1:0] tps_div100;
  } tps_cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [5:0] sw_minutes;
    logic [5:0] sw_seconds;
    logic [6:0] sw_centis;
    logic       field_blanked;
    logic       sw_running;
  } result_t;

  function automatic logic [TPS_WIDTH-1:0] div5(input logic [TPS_WIDTH-1:0] x);
    logic [RECIP_W-1:0] p;
    p = RECIP_W'(x) * RECIP_W'(DIV5_MUL);
    return TPS_WIDTH'(p >> DIV5_SHIFT);
  endfunction

  function automatic logic [TPS_WIDTH-1:0] div100(input logic [TPS_WIDTH-1:0] x);
    logic [RECIP_W-1:0] p;
    p = RECIP_W'(x) * RECIP_W'(DIV100_MUL);
    return TPS_WIDTH'(p >> DIV100_SHIFT);
  endfunction

endpackage

// ----- sv/watch_clock_set_stopwatch_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// watch_clock_set_stopwatch_top
// 24-hour watch with time setting and stopwatch, one result word per tick.
//
// Input stream: each word is one timebase tick carrying the two active-low
// button levels. Output stream: one word per tick with mode, time of day,
// stopwatch value and the blink / run flags.
// A tick's result is registered into the output word, or the skid word if stalled.
// One tick per cycle while s_axis_tready is high; the state update is a single
// pass of increment / compare logic behind the input handshake.
// The output register has a one-word skid stage: while the receiver stalls,
// one more tick is still taken, then s_axis_tready drops until the output
// drains. No word is lost or repeated.
// ticks_per_second is written through APB at address 0; the derived rates
// 1/5 and 1/100 of it are registered at the write, 1/2 is a plain shift.
// Reset: all counters and flags zero, run mode, ticks_per_second = 1000,
// output stream empty.
// ----------------------------------------------------------------------------
module watch_clock_set_stopwatch_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // APB
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [wcs_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  wire logic [wcs_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic      [wcs_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                    pready,
  // input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [7:0]                         s_axis_tdata,  // mode_button_n, set_button_n
  // output stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // mode, hours, minutes, seconds, sw_minutes, sw_seconds, sw_centis,
  // field_blanked, sw_running
  output logic      [47:0]                        m_axis_tdata
);

  localparam int TPW = wcs_pkg::TPS_WIDTH;

  wcs_pkg::tps_cfg_t cfg_q;
  wcs_pkg::result_t  result;
  wcs_pkg::result_t  out_q, out_d, skid_q, skid_d;
  logic              out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic              cfg_write, in_accept, out_take;
  logic [TPW-1:0]    wr_tps;

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == wcs_pkg::REG_TICKS_PER_SECOND);
  assign wr_tps    = pwdata[TPW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tps        <= wcs_pkg::TPS_RESET;
      cfg_q.tps_div5   <= wcs_pkg::TPS5_RESET;
      cfg_q.tps_div100 <= wcs_pkg::TPS100_RESET;
    end else if (cfg_write) begin
      cfg_q.tps        <= wr_tps;
      cfg_q.tps_div5   <= wcs_pkg::div5(wr_tps);
      cfg_q.tps_div100 <= wcs_pkg::div100(wr_tps);
    end
  end

  always_comb begin
    if (paddr[2] == wcs_pkg::REG_TICKS_PER_SECOND) begin
      prdata = {{(wcs_pkg::APB_DATA_WIDTH - TPW){1'b0}}, cfg_q.tps};
    end else begin
      prdata = '0;
    end
  end

  // streams
  assign s_axis_tready = !skid_valid_q;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_take      = m_axis_tvalid && m_axis_tready;

  wcs_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (in_accept),
    .mode_button_n_i (s_axis_tdata[0]),
    .set_button_n_i  (s_axis_tdata[1]),
    .cfg_i           (cfg_q),
    .result_o        (result)
  );

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (in_accept) begin
      if (!out_valid_q || out_take) begin
        out_d       = result;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = result;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q.sw_running, out_q.field_blanked, out_q.sw_centis,
                          out_q.sw_seconds, out_q.sw_minutes, out_q.seconds,
                          out_q.minutes, out_q.hours, out_q.mode};

endmodule
`default_nettype wire

// ----- sv/wcs_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_core
// Time-of-day, edit and stopwatch state; one update per accepted tick word.
// ----------------------------------------------------------------------------
module wcs_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic              mode_button_n_i,
  input  wire logic              set_button_n_i,
  input  wire wcs_pkg::tps_cfg_t cfg_i,
  output wcs_pkg::result_t       result_o
);

  localparam int TW = wcs_pkg::TICK_COUNT_WIDTH;
  localparam int HW = wcs_pkg::HOLD_WIDTH;
  localparam int CW = wcs_pkg::CMP_WIDTH;

  wcs_pkg::mode_e mode_q, mode_d;
  logic [4:0]    hour_q, hour_d;
  logic [5:0]    min_q, min_d, sec_q, sec_d;
  logic [TW-1:0] spre_q, spre_d;
  logic          mlat_q, mlat_d, slat_q, slat_d;
  logic [HW-1:0] hold_q, hold_d;
  logic [TW-1:0] rep_q, rep_d, blink_q, blink_d;
  logic          blank_q, blank_d;
  logic [TW-1:0] swpre_q, swpre_d;
  logic [6:0]    swc_q, swc_d;
  logic [5:0]    sws_q, sws_d, swm_q, swm_d;
  logic          swrun_q, swrun_d;

  logic mode_pressed, set_pressed;
  logic bump_first, bump_repeat;
  logic edit_mode;

  assign mode_pressed = !mode_button_n_i;
  assign set_pressed  = !set_button_n_i;

  always_comb begin
    mode_d  = mode_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    spre_d  = spre_q;
    mlat_d  = mlat_q;
    slat_d  = slat_q;
    hold_d  = hold_q;
    rep_d   = rep_q;
    blink_d = blink_q;
    blank_d = blank_q;
    swpre_d = swpre_q;
    swc_d   = swc_q;
    sws_d   = sws_q;
    swm_d   = swm_q;
    swrun_d = swrun_q;
    bump_first  = 1'b0;
    bump_repeat = 1'b0;

    // mode button edge
    if (!mlat_q && mode_pressed) begin
      mlat_d  = 1'b1;
      blank_d = 1'b0;
      case (mode_q)
        wcs_pkg::MODE_RUN:      mode_d = wcs_pkg::MODE_SET_HOUR;
        wcs_pkg::MODE_SET_HOUR: mode_d = wcs_pkg::MODE_SET_MIN;
        wcs_pkg::MODE_SET_MIN:  mode_d = wcs_pkg::MODE_SET_SEC;
        wcs_pkg::MODE_SET_SEC:  mode_d = wcs_pkg::MODE_STOPWATCH;
        default:                mode_d = wcs_pkg::MODE_RUN;
      endcase
    end else if (!mode_pressed) begin
      mlat_d = 1'b0;
    end

    edit_mode = mode_d inside {wcs_pkg::MODE_SET_HOUR, wcs_pkg::MODE_SET_MIN,
                               wcs_pkg::MODE_SET_SEC};

    // second prescaler and clock advance
    spre_d = spre_q + TW'(1);
    if (CW'(spre_d) == CW'(cfg_i.tps)) begin
      spre_d = '0;
      sec_d  = sec_d + 6'd1;
      if (mode_d == wcs_pkg::MODE_SET_SEC) blank_d = 1'b0;
      if (sec_d > wcs_pkg::MINSEC_MAX) begin
        sec_d = '0;
        min_d = min_d + 6'd1;
        if (mode_d == wcs_pkg::MODE_SET_MIN) blank_d = 1'b0;
      end
      if (min_d > wcs_pkg::MINSEC_MAX) begin
        min_d  = '0;
        hour_d = hour_d + 5'd1;
        if (mode_d == wcs_pkg::MODE_SET_HOUR) blank_d = 1'b0;
      end
      if (hour_d > wcs_pkg::HOUR_MAX && min_d == '0 && sec_d == '0) hour_d = '0;
    end

    if (edit_mode) begin
      // blink
      blink_d = blink_q + TW'(1);
      if (CW'(blink_d) == CW'(cfg_i.tps >> 1)) blank_d = 1'b1;
      if (CW'(blink_d) == CW'(cfg_i.tps)) begin
        blink_d = '0;
        blank_d = 1'b0;
      end
      // edit
      if (set_pressed) begin
        if (hold_q != '1) hold_d = hold_q + HW'(1);
        if (!slat_q) begin
          slat_d     = 1'b1;
          bump_first = 1'b1;
        end
        if (CW'(hold_d) > CW'(cfg_i.tps)) begin
          rep_d = rep_q + TW'(1);
          if (CW'(rep_d) == CW'(cfg_i.tps_div5)) begin
            rep_d       = '0;
            bump_repeat = 1'b1;
          end
        end
      end else begin
        slat_d = 1'b0;
        hold_d = '0;
        rep_d  = '0;
      end
      if (bump_first || bump_repeat) blank_d = 1'b0;
      case (mode_d)
        wcs_pkg::MODE_SET_HOUR: begin
          if (bump_first)  hour_d = (hour_d >= wcs_pkg::HOUR_MAX) ? '0 : hour_d + 5'd1;
          if (bump_repeat) hour_d = (hour_d >= wcs_pkg::HOUR_MAX) ? '0 : hour_d + 5'd1;
        end
        wcs_pkg::MODE_SET_MIN: begin
          if (bump_first)  min_d = (min_d >= wcs_pkg::MINSEC_MAX) ? '0 : min_d + 6'd1;
          if (bump_repeat) min_d = (min_d >= wcs_pkg::MINSEC_MAX) ? '0 : min_d + 6'd1;
        end
        default: begin
          if (bump_first)  sec_d = (sec_d >= wcs_pkg::MINSEC_MAX) ? '0 : sec_d + 6'd1;
          if (bump_repeat) sec_d = (sec_d >= wcs_pkg::MINSEC_MAX) ? '0 : sec_d + 6'd1;
        end
      endcase
    end else if (mode_d == wcs_pkg::MODE_STOPWATCH) begin
      if (set_pressed && !slat_q) begin
        slat_d  = 1'b1;
        swrun_d = !swrun_q;
      end
      if (!set_pressed) slat_d = 1'b0;
      if (swrun_d) begin
        swpre_d = swpre_q + TW'(1);
        if (CW'(swpre_d) == CW'(cfg_i.tps_div100)) begin
          swpre_d = '0;
          swc_d   = swc_q + 7'd1;
          if (swc_d > wcs_pkg::CENTI_MAX) begin
            swc_d = '0;
            sws_d = sws_q + 6'd1;
          end
          if (sws_d > wcs_pkg::MINSEC_MAX) begin
            sws_d = '0;
            swm_d = swm_q + 6'd1;
          end
          if (swm_d > wcs_pkg::MINSEC_MAX && sws_d == '0 && swc_d == '0) swm_d = '0;
        end
      end else begin
        swpre_d = '0;
      end
    end else begin
      swc_d   = '0;
      sws_d   = '0;
      swm_d   = '0;
      swrun_d = 1'b0;
      swpre_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= wcs_pkg::MODE_RUN;
      hour_q  <= '0;
      min_q   <= '0;
      sec_q   <= '0;
      spre_q  <= '0;
      mlat_q  <= 1'b0;
      slat_q  <= 1'b0;
      hold_q  <= '0;
      rep_q   <= '0;
      blink_q <= '0;
      blank_q <= 1'b0;
      swpre_q <= '0;
      swc_q   <= '0;
      sws_q   <= '0;
      swm_q   <= '0;
      swrun_q <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      hour_q  <= hour_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      spre_q  <= spre_d;
      mlat_q  <= mlat_d;
      slat_q  <= slat_d;
      hold_q  <= hold_d;
      rep_q   <= rep_d;
      blink_q <= blink_d;
      blank_q <= blank_d;
      swpre_q <= swpre_d;
      swc_q   <= swc_d;
      sws_q   <= sws_d;
      swm_q   <= swm_d;
      swrun_q <= swrun_d;
    end
  end

  always_comb begin
    result_o.mode          = mode_d;
    result_o.hours         = hour_d;
    result_o.minutes       = min_d;
    result_o.seconds       = sec_d;
    result_o.sw_minutes    = swm_d;
    result_o.sw_seconds    = sws_d;
    result_o.sw_centis     = swc_d;
    result_o.field_blanked = edit_mode && blank_d;
    result_o.sw_running    = swrun_d;
  end

endmodule
`default_nettype wire

// ----- sv/wcs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_checker
// Port-level checks of the watch / stopwatch block, bound to the top level.
// ----------------------------------------------------------------------------
module wcs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);

  logic [2:0] mode_f;
  logic [4:0] hours_f;
  logic       blank_f, run_f;

  assign mode_f  = m_axis_tdata[2:0];
  assign hours_f = m_axis_tdata[7:3];
  assign blank_f = m_axis_tdata[39];
  assign run_f   = m_axis_tdata[40];

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // input stalls only with a full output
  a_skid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // blink only in set modes
  a_blank_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && blank_f |->
      (mode_f == wcs_pkg::MODE_SET_HOUR) || (mode_f == wcs_pkg::MODE_SET_MIN) ||
      (mode_f == wcs_pkg::MODE_SET_SEC))
    else $error("field blanked outside set modes");

  // run mode keeps stopwatch cleared
  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mode_f == wcs_pkg::MODE_RUN |-> !run_f && m_axis_tdata[38:20] == '0)
    else $error("stopwatch not cleared in run mode");

  // hours stay in range
  a_hours: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> hours_f <= wcs_pkg::HOUR_MAX)
    else $error("hours out of range");

endmodule

bind watch_clock_set_stopwatch_top wcs_checker u_wcs_checker (.*);
`default_nettype wire
